### hw/rtl/smpq_pkg.sv
// Shared types and constants of the sorted maximum priority queue.
`timescale 1ns / 1ps

package smpq_pkg;

    // Store and word geometry.
    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int CFG_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    // Capacity register value after reset.
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    // Value reported for an absent entry.
    localparam logic signed [VALUE_W-1:0] NONE_VALUE = -32'sd1;

    // Operation codes.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Input word.
    typedef struct packed {
        logic                      cmd;
        logic signed [VALUE_W-1:0] value;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] popped_value;
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] rear_value;
        logic [COUNT_W-1:0]        count;
        logic                      is_empty;
        logic                      is_full;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic read;
        logic place;
        logic step;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic reject;
        logic is_pop;
        logic idx_zero;
        logic scan_end;
        logic stop;
    } t_dp_stat;

endpackage

### hw/rtl/sorted_max_priority_queue.sv
// Top level of the sorted maximum priority queue.
`timescale 1ns / 1ps

// The queue holds up to the programmed capacity of signed 32-bit values in a
// single-port store kept in descending order; equal values leave in arrival
// order. A word is taken when start is high and busy is low, and exactly one
// result word follows, shown for one cycle with o_valid high; the receiver
// cannot stall it, so it must take every result in that cycle. A push
// moves each smaller entry it compares back by one place, until it stops
// behind an entry greater than or equal to it or reaches the front of the
// queue; a pop moves each entry behind the front forward by one place. A
// rejected push or pop leaves the store untouched. Write the capacity
// register only while busy is low and no result is pending.
module sorted_max_priority_queue #(
    parameter int DEPTH = smpq_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  smpq_pkg::t_in_word         i_word,
    input  logic                       i_cfg_wr_en,
    input  logic [smpq_pkg::CFG_W-1:0] i_cfg_wdata,
    output logic                       o_valid,
    output smpq_pkg::t_out_word        o_word
);
    import smpq_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer.
    smpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // Store and result datapath.
    smpq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_word),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_valid     (o_valid),
        .o_out_word  (o_word)
    );

endmodule

### hw/rtl/smpq_ctrl.sv
// Controller state machine of the sorted maximum priority queue.
`timescale 1ns / 1ps

module smpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  smpq_pkg::t_dp_stat i_stat,
    output smpq_pkg::t_dp_cmd  o_cmd
);
    import smpq_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_STEP  = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_stat.reject) begin
                    n_state = ST_FIN;
                end else if (!i_stat.is_pop) begin
                    if (i_stat.idx_zero) begin
                        o_cmd.place = 1'b1;
                        n_state     = ST_FIN;
                    end else begin
                        o_cmd.read = 1'b1;
                        n_state    = ST_STEP;
                    end
                end else if (i_stat.scan_end) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.read = 1'b1;
                    n_state    = ST_STEP;
                end
            end
            ST_STEP: begin
                o_cmd.step = 1'b1;
                if (!i_stat.is_pop && i_stat.stop) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_CHECK;
                end
            end
            ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

### hw/rtl/smpq_datapath.sv
// Datapath of the sorted maximum priority queue: store, counters and result word.
`timescale 1ns / 1ps

module smpq_datapath #(
    parameter int DEPTH = smpq_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  smpq_pkg::t_in_word           i_in_word,
    input  logic                         i_cfg_wr_en,
    input  logic [smpq_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  smpq_pkg::t_dp_cmd            i_cmd,
    output smpq_pkg::t_dp_stat           o_stat,
    output logic                         o_valid,
    output smpq_pkg::t_out_word          o_out_word
);
    import smpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > CFG_W) ? CW : CFG_W;

    // Entry store, kept in descending order from address zero.
    logic signed [VALUE_W-1:0] mem [DEPTH];

    logic [CFG_W-1:0]          r_cfg;
    logic [CW-1:0]             r_held;
    logic [CW-1:0]             r_idx;
    logic                      r_cmd;
    logic signed [VALUE_W-1:0] r_val;
    logic signed [VALUE_W-1:0] r_rd_data;
    logic signed [VALUE_W-1:0] r_popped;
    logic signed [VALUE_W-1:0] r_front;
    logic signed [VALUE_W-1:0] r_rear;
    logic                      r_valid;
    t_out_word                 r_out_word;

    logic [MW-1:0]             held_w;
    logic [MW-1:0]             cfg_w;
    logic [MW-1:0]             cap_use;
    logic                      is_pop;
    logic                      reject;
    logic [CW-1:0]             rd_addr_full;
    logic [CW-1:0]             wr_addr_full;
    logic                      less;
    logic                      we;
    logic signed [VALUE_W-1:0] wdata;
    logic [CW-1:0]             n_held;
    logic signed [VALUE_W-1:0] n_front;
    logic signed [VALUE_W-1:0] n_rear;
    logic                      n_empty;

    // Capacity in use: zero counts as one, above the store depth as the depth.
    assign held_w = MW'(r_held);
    assign cfg_w  = MW'(r_cfg);
    always_comb begin
        if (cfg_w == '0) begin
            cap_use = MW'(1);
        end else if (cfg_w > MW'(DEPTH)) begin
            cap_use = MW'(DEPTH);
        end else begin
            cap_use = cfg_w;
        end
    end

    // Status toward the controller.
    assign is_pop = (r_cmd == CMD_POP);
    assign reject = is_pop ? (r_held == '0) : (held_w >= cap_use);
    assign less   = (r_rd_data < r_val);

    assign o_stat.reject   = reject;
    assign o_stat.is_pop   = is_pop;
    assign o_stat.idx_zero = (r_idx == '0);
    assign o_stat.scan_end = (r_idx >= r_held);
    assign o_stat.stop     = !less;

    // A push reads the entry ahead of the hole; a pop reads the entry to move forward.
    assign rd_addr_full = is_pop ? r_idx : (r_idx - CW'(1));
    assign wr_addr_full = is_pop ? (r_idx - CW'(1)) : r_idx;

    // Store write: place the new value, or move one entry by one place.
    always_comb begin
        we    = 1'b0;
        wdata = r_val;
        if (i_cmd.place) begin
            we = 1'b1;
        end else if (i_cmd.step) begin
            if (is_pop) begin
                we    = (r_idx != '0);
                wdata = r_rd_data;
            end else begin
                we    = 1'b1;
                wdata = less ? r_rd_data : r_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr_full[AW-1:0]] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_data <= mem[rd_addr_full[AW-1:0]];
        end
    end

    // Item registers and the scan index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_in_word.cmd;
            r_val <= i_in_word.value;
            r_idx <= (i_in_word.cmd == CMD_POP) ? '0 : r_held;
        end else if (i_cmd.step) begin
            if (is_pop) begin
                r_idx <= r_idx + CW'(1);
            end else if (less) begin
                r_idx <= r_idx - CW'(1);
            end
        end
    end

    // The popped value and the new front are caught as the pop walks the store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && is_pop) begin
            if (r_idx == '0) begin
                r_popped <= r_rd_data;
            end else if (r_idx == CW'(1)) begin
                r_front <= r_rd_data;
            end
        end else if (i_cmd.finish) begin
            r_front <= n_front;
            r_rear  <= n_rear;
        end
    end

    // Count, front and rear after the item.
    always_comb begin
        n_held  = r_held;
        n_front = r_front;
        n_rear  = r_rear;
        if (!reject) begin
            if (is_pop) begin
                n_held = r_held - CW'(1);
            end else begin
                n_held = r_held + CW'(1);
                if (r_idx == '0) begin
                    n_front = r_val;
                end
                if (r_idx == r_held) begin
                    n_rear = r_val;
                end
            end
        end
    end

    assign n_empty = (n_held == '0);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= CAP_RESET;
            r_held  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.finish) begin
                r_held <= n_held;
            end
        end
    end

    // Result word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (reject) begin
                r_out_word.status <= is_pop ? STATUS_EMPTY : STATUS_FULL;
            end else begin
                r_out_word.status <= STATUS_DONE;
            end
            r_out_word.popped_value <= (is_pop && !reject) ? r_popped : NONE_VALUE;
            r_out_word.front_value  <= n_empty ? NONE_VALUE : n_front;
            r_out_word.rear_value   <= n_empty ? NONE_VALUE : n_rear;
            r_out_word.count        <= COUNT_W'(MW'(n_held));
            r_out_word.is_empty     <= n_empty;
            r_out_word.is_full      <= (MW'(n_held) >= cap_use);
        end
    end

    assign o_valid    = r_valid;
    assign o_out_word = r_out_word;

endmodule
